### rtl/fmvsf_pkg.sv
// ----------------------------------------------------------------------------
// fmvsf_pkg
// Shared types and constants of the FM volume shadow filter.
// ----------------------------------------------------------------------------
package fmvsf_pkg;

    // Register index codes of the configuration port
    localparam logic CFG_VOLUME_OFFSET = 1'b0;
    localparam logic CFG_CHIP_PRESENT  = 1'b1;

    // Reset value of the volume offset (-12)
    localparam logic signed [7:0] VOLUME_RESET = -8'sd12;
    // Offset used for a mute request (-127)
    localparam logic signed [7:0] MUTE_OFFSET  = -8'sd127;

    // Address decode of the chip register map
    localparam logic [7:0] LEVEL_MASK = 8'hE0;
    localparam logic [7:0] LEVEL_BASE = 8'h60;
    localparam logic [7:0] ALGO_MASK  = 8'hF8;
    localparam logic [7:0] ALGO_BASE  = 8'h20;

    // Largest total level (silence)
    localparam logic [6:0] LEVEL_MAX = 7'h7F;

    // Request kinds as sorted by the front end
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_LEVEL,
        KIND_ALGO,
        KIND_MUTE
    } t_kind;

    // One queued request
    typedef struct packed {
        t_kind      kind;
        logic [7:0] addr;
        logic [7:0] data;
        logic       mute;
    } t_cmd;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Carrier operator mask per algorithm number
    function automatic logic [3:0] carrier_lookup(input logic [2:0] algo);
        logic [3:0] m;
        unique case (algo)
            3'd0, 3'd1, 3'd2, 3'd3: m = 4'h8;
            3'd4:                   m = 4'hC;
            3'd5, 3'd6:             m = 4'hE;
            3'd7:                   m = 4'hF;
            default:                m = 4'h8;
        endcase
        return m;
    endfunction

endpackage

### rtl/fmvsf_front.sv
// ----------------------------------------------------------------------------
// fmvsf_front
// Takes requests from the input stream, sorts them by kind and pushes them
// into the queue; requests are dropped while the chip is absent.
// ----------------------------------------------------------------------------
module fmvsf_front
    import fmvsf_pkg::*;
(
    input  logic       i_s_valid,
    output logic       o_s_ready,
    input  logic       i_op,
    input  logic [7:0] i_addr,
    input  logic [7:0] i_data,
    input  logic       i_mute,
    input  logic       i_chip_present,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    // Accept whenever the queue has room
    assign o_s_ready = !i_q_stat.full;
    assign o_push    = i_s_valid && !i_q_stat.full && i_chip_present;

    // Classify by op and address range
    always_comb begin
        priority if (i_op) begin
            o_cmd.kind = KIND_MUTE;
        end else if ((i_addr & LEVEL_MASK) == LEVEL_BASE) begin
            o_cmd.kind = KIND_LEVEL;
        end else if ((i_addr & ALGO_MASK) == ALGO_BASE) begin
            o_cmd.kind = KIND_ALGO;
        end else begin
            o_cmd.kind = KIND_PASS;
        end
        o_cmd.addr = i_addr;
        o_cmd.data = i_data;
        o_cmd.mute = i_mute;
    end

endmodule

### rtl/fmvsf_queue.sv
// ----------------------------------------------------------------------------
// fmvsf_queue
// Two-entry request queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module fmvsf_queue
    import fmvsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

### rtl/fmvsf_back.sv
// ----------------------------------------------------------------------------
// fmvsf_back
// Request sequencer: keeps the level shadow and carrier masks, emits the
// chip writes of each request through a hold stage and an output register.
// ----------------------------------------------------------------------------
module fmvsf_back
    import fmvsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    input  logic signed [7:0] i_volume_offset,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [7:0]        o_m_addr,
    output logic [7:0]        o_m_data,
    output logic              o_m_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Level minus offset, saturated to the 7-bit range
    function automatic logic [6:0] adjust(input logic [6:0] level,
                                          input logic signed [7:0] vol);
        logic signed [9:0] t;
        t = $signed({3'b000, level}) - $signed({{2{vol[7]}}, vol});
        if (t > 10'sd127 || t < 10'sd0) begin
            return vol[7] ? LEVEL_MAX : 7'h00;
        end
        return t[6:0];
    endfunction

    t_state            r_state;
    t_cmd              r_cmd;
    logic [6:0]        r_shadow [32];
    logic [3:0]        r_mask [8];
    logic [4:0]        r_idx;
    logic [3:0]        r_sel;
    logic              r_mute_mode;
    logic signed [7:0] r_vol;
    logic              r_hold_valid;
    logic [7:0]        r_hold_addr;
    logic [7:0]        r_hold_data;
    logic              r_out_valid;
    logic [7:0]        r_out_addr;
    logic [7:0]        r_out_data;
    logic              r_out_last;

    logic       out_free;
    logic       hold_free;
    logic [2:0] scan_ch;
    logic [1:0] scan_k;
    logic       scan_carrier;
    logic       scan_sel;
    logic [6:0] scan_level;
    logic [7:0] scan_data;
    logic [2:0] wr_ch;
    logic       wr_carrier;
    logic [7:0] wr_data;
    logic [3:0] new_mask;
    logic [3:0] changed;
    logic       scan_end;
    logic       emit;
    logic [7:0] cand_addr;
    logic [7:0] cand_data;
    logic       flush_done;

    assign out_free  = !r_out_valid || i_m_ready;
    assign hold_free = !r_hold_valid || out_free;
    assign o_pop     = (r_state == S_IDLE) && !i_q_stat.empty;

    // Scan of one operator slot: index is {channel, slot}
    assign scan_ch      = r_idx[4:2];
    assign scan_k       = r_idx[1:0];
    assign scan_carrier = r_mask[scan_ch][scan_k];
    assign scan_sel     = r_mute_mode ? scan_carrier : r_sel[scan_k];
    assign scan_level   = r_shadow[{scan_k, scan_ch}];
    assign scan_data    = {1'b0, scan_carrier ? adjust(scan_level, r_vol) : scan_level};
    assign scan_end     = r_mute_mode ? (r_idx == 5'd31) : (scan_k == 2'd3);

    // Direct write: level adjust and algorithm mask update
    assign wr_ch      = r_cmd.addr[2:0];
    assign wr_carrier = r_mask[wr_ch][r_cmd.addr[4:3]];
    assign new_mask   = carrier_lookup(r_cmd.data[2:0]);
    assign changed    = r_mask[wr_ch] ^ new_mask;

    always_comb begin
        if (r_cmd.kind == KIND_LEVEL) begin
            wr_data = {1'b0, wr_carrier ? adjust(r_cmd.data[6:0], i_volume_offset)
                                        : r_cmd.data[6:0]};
        end else begin
            wr_data = r_cmd.data;
        end
    end

    // Candidate write into the hold stage
    always_comb begin
        emit      = 1'b0;
        cand_addr = r_cmd.addr;
        cand_data = wr_data;
        if (r_state == S_WRITE) begin
            emit = hold_free;
        end else if (r_state == S_SCAN) begin
            emit      = scan_sel && hold_free;
            cand_addr = LEVEL_BASE | {3'b000, scan_k, scan_ch};
            cand_data = scan_data;
        end
    end

    assign flush_done = (r_state == S_FLUSH) && r_hold_valid && out_free;

    // Sequencer state, tables and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 32; i++) begin
                r_shadow[i] <= LEVEL_MAX;
            end
            for (int i = 0; i < 8; i++) begin
                r_mask[i] <= 4'h0;
            end
        end else begin
            // output register: earlier result goes out ahead of a newer one
            if (emit && r_hold_valid) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= r_hold_addr;
                r_out_data  <= r_hold_data;
                r_out_last  <= 1'b0;
            end else if (flush_done) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= r_hold_addr;
                r_out_data  <= r_hold_data;
                r_out_last  <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end

            // hold stage keeps the newest result until its last flag is known
            if (emit) begin
                r_hold_valid <= 1'b1;
                r_hold_addr  <= cand_addr;
                r_hold_data  <= cand_data;
            end else if (flush_done) begin
                r_hold_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.kind == KIND_MUTE) begin
                            r_mute_mode <= 1'b1;
                            r_vol       <= i_cmd.mute ? MUTE_OFFSET : i_volume_offset;
                            r_idx       <= 5'd0;
                            r_state     <= S_SCAN;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    if (hold_free) begin
                        if (r_cmd.kind == KIND_LEVEL) begin
                            r_shadow[r_cmd.addr[4:0]] <= r_cmd.data[6:0];
                        end
                        if (r_cmd.kind == KIND_ALGO && changed != 4'h0) begin
                            r_mask[wr_ch] <= new_mask;
                            r_sel         <= changed;
                            r_mute_mode   <= 1'b0;
                            r_vol         <= i_volume_offset;
                            r_idx         <= {wr_ch, 2'b00};
                            r_state       <= S_SCAN;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_SCAN: begin
                    if (!scan_sel || hold_free) begin
                        if (scan_end) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_valid || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_addr  = r_out_addr;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

endmodule

### rtl/fm_opm_volume_shadow_filter_unit.sv
// ----------------------------------------------------------------------------
// fm_opm_volume_shadow_filter_unit
// Register-write filter in front of an FM synthesizer: shadows total levels,
// applies a volume offset to carriers and handles mute requests.
// ----------------------------------------------------------------------------
// Each request passes the front end into a two-entry queue and is then run by
// the sequencer, which emits its chip writes one per cycle while the output
// does not stall. A plain or level write passes the sequencer states pick-up,
// write and flush, and its result reaches the output through the hold stage
// and the output register. An algorithm change that alters the carrier mask
// scans the four slots of its channel, one per cycle, and adds up to four
// level rewrites. A mute request scans all 32 operator slots one per cycle,
// whatever the number of carriers. Output stalls hold each scan. The
// single-slot scan of the sequencer sets the rate. Each result is held one
// stage until it is known whether it is the last of its request, and tlast
// marks that final write. While chip_present is 0, requests are taken and
// dropped without effect.
// ----------------------------------------------------------------------------
module fm_opm_volume_shadow_filter_unit
    import fmvsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] reg_addr_in, [15:8] reg_data_in,
                                         // [16] mute_on, [23:17] zero
    input  logic        i_s_axis_tuser,  // [0] op
    // chip write stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] reg_addr_out, [15:8] reg_data_out
    output logic        o_m_axis_tlast   // last
);

    logic signed [7:0] r_volume_offset;
    logic              r_chip_present;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_front_cmd;
    t_cmd    w_q_cmd;
    t_q_stat w_q_stat;
    logic [7:0] w_out_addr;
    logic [7:0] w_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_offset <= VOLUME_RESET;
            r_chip_present  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLUME_OFFSET: r_volume_offset <= $signed(i_cfg_wdata);
                CFG_CHIP_PRESENT:  r_chip_present  <= i_cfg_wdata[0];
                default:           r_chip_present  <= r_chip_present;
            endcase
        end
    end

    fmvsf_front u_front (
        .i_s_valid      (i_s_axis_tvalid),
        .o_s_ready      (o_s_axis_tready),
        .i_op           (i_s_axis_tuser),
        .i_addr         (i_s_axis_tdata[7:0]),
        .i_data         (i_s_axis_tdata[15:8]),
        .i_mute         (i_s_axis_tdata[16]),
        .i_chip_present (r_chip_present),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    fmvsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    fmvsf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_q_cmd),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .i_volume_offset (r_volume_offset),
        .o_m_valid       (o_m_axis_tvalid),
        .i_m_ready       (i_m_axis_tready),
        .o_m_addr        (w_out_addr),
        .o_m_data        (w_out_data),
        .o_m_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_out_data, w_out_addr};

    // Queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("request queue overflow");

    // Queue never read while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("request queue underflow");

    // Requests are dropped while the chip is absent
    a_absent_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_chip_present |-> !w_push)
        else $error("request queued while chip absent");

endmodule
